// File: sv/pen_tablet_report_engine_top_assert.svh
// Assertion macros for the pen tablet report engine checker.
// Used by ptre_checker.sv; needs clk and arst_n in scope.
`ifndef PEN_TABLET_REPORT_ENGINE_TOP_ASSERT_SVH
`define PEN_TABLET_REPORT_ENGINE_TOP_ASSERT_SVH

// checked out of reset only
`define PTRE_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// checked at every edge, reset included
`define PTRE_ASSERT_ALWAYS(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// File: sv/ptre_pkg.sv
// Shared types, constants and byte formatting for the pen tablet report engine.
// No dependencies; imported by every RTL module and the testbench.
`timescale 1ns / 1ps

package ptre_pkg;

	localparam int unsigned RES_X_DEFAULT   = 44704;
	localparam int unsigned RES_Y_DEFAULT   = 27940;
	localparam int unsigned QUEUE_DEPTH_DEF = 2;

	localparam logic [10:0] PRESSURE_RESET  = 11'd890;
	localparam logic [15:0] LEAVE_RESET     = 16'd5000;
	localparam logic [15:0] PING_RESET      = 16'd200;
	localparam logic [31:0] TOOL_ID         = 32'h0000_0802;
	localparam logic [31:0] TOOL_SERIAL     = 32'hFEED_C0DE;
	localparam logic [7:0]  REPORT_ID_PEN   = 8'h02;
	localparam logic [7:0]  FLAG_PROX       = 8'h80;
	localparam logic [7:0]  FLAG_READY      = 8'h40;
	localparam logic [7:0]  FLAG_RANGE      = 8'h20;
	localparam logic [7:0]  FLAG_SERIAL     = 8'h02;
	localparam logic [7:0]  TILT_CENTER     = 8'd64;
	localparam logic [3:0]  HOVER_DISTANCE  = 4'd10;

	// register indexes
	localparam logic [1:0] REG_MODE  = 2'd0;
	localparam logic [1:0] REG_LEAVE = 2'd1;
	localparam logic [1:0] REG_PING  = 2'd2;

	// input operations
	localparam logic OP_EVENT = 1'b0;
	localparam logic OP_POLL  = 1'b1;

	typedef enum logic [1:0] {
		KIND_NAK,
		KIND_PROX,
		KIND_PEN
	} kind_t;

	typedef struct packed {
		kind_t       kind;
		logic        prox;
		logic [15:0] x;
		logic [14:0] y;
		logic [10:0] pressure;
		logic [2:0]  btn;
	} rpt_t;

	typedef struct packed {
		logic full;
		logic empty;
	} q_stat_t;

	// floor(p / 32767) for a 31-bit product, by folding the high half back in
	function automatic logic [16:0] div_full_scale(input logic [30:0] p);
		logic [15:0] q0;
		logic [16:0] r0;
		logic [1:0]  q1;
		logic [15:0] r1;
		logic        c;
		q0 = p[30:15];
		r0 = {2'b00, p[14:0]} + {1'b0, q0};
		q1 = r0[16:15];
		r1 = {1'b0, r0[14:0]} + {14'd0, q1};
		c  = (r1 >= 16'd32767);
		return {1'b0, q0} + {15'd0, q1} + {16'd0, c};
	endfunction

	// returns {last, byte} for beat idx of a queued report
	function automatic logic [8:0] report_beat(input rpt_t r, input logic [3:0] idx);
		logic [10:0] pr;
		logic [3:0]  hover;
		logic [7:0]  b;
		logic        last;
		pr    = r.btn[0] ? r.pressure : 11'd0;
		hover = r.btn[0] ? 4'd0 : HOVER_DISTANCE;
		b     = 8'd0;
		last  = 1'b0;
		case (r.kind)
			KIND_PROX: begin
				last = (idx == 4'd8);
				case (idx)
					4'd0: b = REPORT_ID_PEN;
					4'd1: b = FLAG_PROX | (r.prox ? (FLAG_READY | FLAG_SERIAL) : 8'h00);
					4'd2: b = TOOL_ID[11:4];
					4'd3: b = {TOOL_ID[3:0], TOOL_SERIAL[31:28]};
					4'd4: b = TOOL_SERIAL[27:20];
					4'd5: b = TOOL_SERIAL[19:12];
					4'd6: b = TOOL_SERIAL[11:4];
					4'd7: b = {TOOL_SERIAL[3:0], TOOL_ID[19:16]};
					4'd8: b = {TOOL_ID[15:12], 4'h0};
					default: b = 8'h00;
				endcase
			end
			KIND_PEN: begin
				last = (idx == 4'd9);
				case (idx)
					4'd0: b = REPORT_ID_PEN;
					4'd1: b = FLAG_PROX | FLAG_READY | FLAG_RANGE
						| {5'd0, r.btn[2:1], pr[0]};
					4'd2: b = {1'b0, r.x[15:9]};
					4'd3: b = r.x[8:1];
					4'd4: b = {2'b00, r.y[14:9]};
					4'd5: b = r.y[8:1];
					4'd6: b = pr[10:3];
					4'd7: b = {pr[2:1], TILT_CENTER[6:1]};
					4'd8: b = {TILT_CENTER[0], TILT_CENTER[6:0]};
					4'd9: b = {2'b00, hover, r.x[0], r.y[0]};
					default: b = 8'h00;
				endcase
			end
			default: begin
				b    = 8'h00;
				last = 1'b1;
			end
		endcase
		return {last, b};
	endfunction

endpackage

// File: sv/ptre_front.sv
// Front part: accepts events and polls, keeps the pen state and classifies polls.
// Depends on ptre_pkg; pushes one report descriptor per poll into ptre_queue.
`timescale 1ns / 1ps

module ptre_front
	import ptre_pkg::*;
#(
	parameter int unsigned RESOLUTION_X = RES_X_DEFAULT,
	parameter int unsigned RESOLUTION_Y = RES_Y_DEFAULT
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        req_valid,
	output logic        req_stall,
	input  logic        op,
	input  logic [31:0] now_ms,
	input  logic [14:0] pointer_x,
	input  logic [14:0] pointer_y,
	input  logic signed [7:0] wheel_delta,
	input  logic [2:0]  buttons,
	input  logic        wr_en,
	input  logic [1:0]  wr_index,
	input  logic [15:0] wr_data,
	input  q_stat_t     q_stat,
	output logic        push,
	output rpt_t        push_rpt
);

	logic        v_s1;
	logic        op_s1;
	logic [31:0] now_s1;
	logic [30:0] prod_x_s1;
	logic [30:0] prod_y_s1;
	logic [7:0]  dz_s1;
	logic [2:0]  btn_s1;

	logic        mode_q;
	logic [15:0] leave_q;
	logic [15:0] ping_q;
	logic [15:0] pen_x_q;
	logic [14:0] pen_y_q;
	logic [10:0] pressure_q;
	logic [2:0]  btn_q;
	logic        prox_q;
	logic        pen_chg_q;
	logic        prox_chg_q;
	logic [31:0] last_rpt_q;
	logic [31:0] last_evt_q;

	logic        go_s1;
	logic        accept;
	logic [16:0] qx;
	logic [16:0] qy;
	logic [15:0] new_x;
	logic [14:0] new_y;
	logic signed [17:0] p_calc;
	logic [10:0] new_pressure;
	logic [31:0] evt_age;
	logic [31:0] rpt_age;
	logic        prox_n;
	logic        pen_chg_n;
	logic        prox_chg_n;
	kind_t       kind_n;

	assign go_s1     = v_s1 && (op_s1 == OP_EVENT || !q_stat.full);
	assign req_stall = v_s1 && !go_s1;
	assign accept    = req_valid && !req_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (accept) begin
			v_s1 <= 1'b1;
		end else if (go_s1) begin
			v_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			op_s1     <= op;
			now_s1    <= now_ms;
			prod_x_s1 <= 31'(pointer_x) * 31'(RESOLUTION_X);
			prod_y_s1 <= 31'(pointer_y) * 31'(RESOLUTION_Y);
			dz_s1     <= wheel_delta;
			btn_s1    <= buttons;
		end
	end

	assign qx    = div_full_scale(prod_x_s1);
	assign qy    = div_full_scale(prod_y_s1);
	assign new_x = qx[16] ? 16'hFFFF : qx[15:0];
	assign new_y = (|qy[16:15]) ? 15'h7FFF : qy[14:0];

	assign p_calc = $signed({7'd0, pressure_q}) - $signed({{3{dz_s1[7]}}, dz_s1, 7'd0});

	always_comb begin
		if (p_calc < 18'sd128) begin
			new_pressure = 11'd128;
		end else if (p_calc > 18'sd2047) begin
			new_pressure = 11'd2047;
		end else begin
			new_pressure = p_calc[10:0];
		end
	end

	assign evt_age = now_s1 - last_evt_q;
	assign rpt_age = now_s1 - last_rpt_q;

	always_comb begin
		prox_n     = prox_q;
		pen_chg_n  = pen_chg_q;
		prox_chg_n = prox_chg_q;
		kind_n     = KIND_NAK;
		if (mode_q) begin
			if (prox_q && !pen_chg_q && evt_age > {16'd0, leave_q}) begin
				prox_n     = 1'b0;
				prox_chg_n = 1'b1;
			end
			if (rpt_age > {16'd0, ping_q}) begin
				if (prox_n) begin
					pen_chg_n = 1'b1;
				end else begin
					prox_chg_n = 1'b1;
				end
			end
			if (prox_chg_n) begin
				kind_n     = KIND_PROX;
				prox_chg_n = 1'b0;
			end else if (pen_chg_n) begin
				kind_n    = KIND_PEN;
				pen_chg_n = 1'b0;
			end
		end
	end

	assign push = go_s1 && op_s1 == OP_POLL;

	always_comb begin
		push_rpt.kind     = kind_n;
		push_rpt.prox     = prox_n;
		push_rpt.x        = pen_x_q;
		push_rpt.y        = pen_y_q;
		push_rpt.pressure = pressure_q;
		push_rpt.btn      = btn_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q     <= 1'b0;
			leave_q    <= LEAVE_RESET;
			ping_q     <= PING_RESET;
			pen_x_q    <= '0;
			pen_y_q    <= '0;
			pressure_q <= PRESSURE_RESET;
			btn_q      <= '0;
			prox_q     <= 1'b0;
			pen_chg_q  <= 1'b0;
			prox_chg_q <= 1'b1;
			last_rpt_q <= '0;
			last_evt_q <= '0;
		end else begin
			if (go_s1 && mode_q) begin
				if (op_s1 == OP_EVENT) begin
					pen_x_q    <= new_x;
					pen_y_q    <= new_y;
					pressure_q <= new_pressure;
					btn_q      <= btn_s1;
					pen_chg_q  <= 1'b1;
					last_evt_q <= now_s1;
					if (!prox_q) begin
						prox_q     <= 1'b1;
						prox_chg_q <= 1'b1;
					end
				end else begin
					prox_q     <= prox_n;
					pen_chg_q  <= pen_chg_n;
					prox_chg_q <= prox_chg_n;
					if (kind_n != KIND_NAK) begin
						last_rpt_q <= now_s1;
					end
				end
			end
			if (wr_en) begin
				case (wr_index)
					REG_MODE: begin
						mode_q     <= wr_data[0];
						prox_q     <= 1'b0;
						pen_chg_q  <= 1'b0;
						prox_chg_q <= 1'b1;
					end
					REG_LEAVE: leave_q <= wr_data;
					REG_PING:  ping_q  <= wr_data;
					default: ;
				endcase
			end
		end
	end

endmodule

// File: sv/ptre_queue.sv
// Short queue of report descriptors between the front and back parts.
// Depends on ptre_pkg for rpt_t and q_stat_t.
`timescale 1ns / 1ps

module ptre_queue
	import ptre_pkg::*;
#(
	parameter int unsigned DEPTH = QUEUE_DEPTH_DEF
) (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    push,
	input  rpt_t    push_rpt,
	input  logic    pop,
	output rpt_t    head,
	output q_stat_t q_stat
);

	localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int unsigned CW = $clog2(DEPTH + 1);

	rpt_t          mem_q [DEPTH];
	logic [AW-1:0] wr_ptr_q;
	logic [AW-1:0] rd_ptr_q;
	logic [CW-1:0] count_q;

	function automatic logic [AW-1:0] bump(input logic [AW-1:0] p);
		return (p == AW'(DEPTH - 1)) ? '0 : p + AW'(1);
	endfunction

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_rpt;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= bump(wr_ptr_q);
			end
			if (pop) begin
				rd_ptr_q <= bump(rd_ptr_q);
			end
			case ({push, pop})
				2'b10:   count_q <= count_q + CW'(1);
				2'b01:   count_q <= count_q - CW'(1);
				default: count_q <= count_q;
			endcase
		end
	end

	assign head         = mem_q[rd_ptr_q];
	assign q_stat.full  = (count_q == CW'(DEPTH));
	assign q_stat.empty = (count_q == '0);

endmodule

// File: sv/ptre_back.sv
// Back part: walks the head descriptor beat by beat into the output register.
// Depends on ptre_pkg for report_beat; pops ptre_queue after the final beat.
`timescale 1ns / 1ps

module ptre_back
	import ptre_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  q_stat_t     q_stat,
	input  rpt_t        head,
	output logic        pop,
	output logic        rsp_valid,
	input  logic        rsp_stall,
	output logic        nak,
	output logic [7:0]  report_byte,
	output logic        last_byte
);

	logic       rsp_valid_q;
	logic       nak_q;
	logic [7:0] byte_q;
	logic       last_q;
	logic [3:0] idx_q;
	logic       load;
	logic [8:0] beat;

	assign load = !q_stat.empty && (!rsp_valid_q || !rsp_stall);
	assign beat = report_beat(head, idx_q);
	assign pop  = load && beat[8];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
			idx_q       <= '0;
		end else if (load) begin
			rsp_valid_q <= 1'b1;
			idx_q       <= beat[8] ? 4'd0 : idx_q + 4'd1;
		end else if (!rsp_stall) begin
			rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			nak_q  <= (head.kind == KIND_NAK);
			byte_q <= beat[7:0];
			last_q <= beat[8];
		end
	end

	assign rsp_valid   = rsp_valid_q;
	assign nak         = nak_q;
	assign report_byte = byte_q;
	assign last_byte   = last_q;

endmodule

// File: sv/pen_tablet_report_engine_top.sv
// Pen tablet report engine: pointer events in, poll answers out as byte beats.
// Uses ptre_pkg, ptre_front, ptre_queue and ptre_back.
//
// Request channel (req_valid/req_stall): op 0 is a pointer event, op 1 a poll.
// One request is taken per cycle while req_stall is low; the front stage holds a
// poll while the queue in front of the byte serialiser is full.
// Response channel (rsp_valid/rsp_stall): a poll gives one NAK beat, a 9-beat
// proximity report or a 10-beat pen report, last_byte marking the end.
// Events give no beats.
// A poll is registered in the front stage, then queued, then loaded as a beat.
// The serialiser sends one beat per cycle unless stalled or out of reports.
// The report queue holds QUEUE_DEPTH polls.
// Write configuration through wr_en/wr_index/wr_data only while the block is
// idle; writing the mode register drops proximity and flags a proximity report.
// Reset clears the pipeline and queue and loads the register and pen defaults.
// A stalled beat holds; the queue can then fill, and a poll then raises req_stall.
`timescale 1ns / 1ps

module pen_tablet_report_engine_top
	import ptre_pkg::*;
#(
	parameter int unsigned RESOLUTION_X = RES_X_DEFAULT,
	parameter int unsigned RESOLUTION_Y = RES_Y_DEFAULT,
	parameter int unsigned QUEUE_DEPTH  = QUEUE_DEPTH_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        req_valid,
	output logic        req_stall,
	input  logic        op,
	input  logic [31:0] now_ms,
	input  logic [14:0] pointer_x,
	input  logic [14:0] pointer_y,
	input  logic signed [7:0] wheel_delta,
	input  logic [2:0]  buttons,
	output logic        rsp_valid,
	input  logic        rsp_stall,
	output logic        nak,
	output logic [7:0]  report_byte,
	output logic        last_byte,
	input  logic        wr_en,
	input  logic [1:0]  wr_index,
	input  logic [15:0] wr_data
);

	q_stat_t q_stat;
	logic    push;
	rpt_t    push_rpt;
	logic    pop;
	rpt_t    head;

	ptre_front #(
		.RESOLUTION_X(RESOLUTION_X),
		.RESOLUTION_Y(RESOLUTION_Y)
	) u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.req_valid  (req_valid),
		.req_stall  (req_stall),
		.op         (op),
		.now_ms     (now_ms),
		.pointer_x  (pointer_x),
		.pointer_y  (pointer_y),
		.wheel_delta(wheel_delta),
		.buttons    (buttons),
		.wr_en      (wr_en),
		.wr_index   (wr_index),
		.wr_data    (wr_data),
		.q_stat     (q_stat),
		.push       (push),
		.push_rpt   (push_rpt)
	);

	ptre_queue #(
		.DEPTH(QUEUE_DEPTH)
	) u_queue (
		.clk     (clk),
		.arst_n  (arst_n),
		.push    (push),
		.push_rpt(push_rpt),
		.pop     (pop),
		.head    (head),
		.q_stat  (q_stat)
	);

	ptre_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.q_stat     (q_stat),
		.head       (head),
		.pop        (pop),
		.rsp_valid  (rsp_valid),
		.rsp_stall  (rsp_stall),
		.nak        (nak),
		.report_byte(report_byte),
		.last_byte  (last_byte)
	);

endmodule

// File: sv/ptre_checker.sv
// Port-level checker for the pen tablet report engine, bound to the top level.
// Depends on pen_tablet_report_engine_top_assert.svh for the assertion macros.
`timescale 1ns / 1ps
`include "pen_tablet_report_engine_top_assert.svh"

module ptre_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        req_valid,
	input logic        req_stall,
	input logic        op,
	input logic [31:0] now_ms,
	input logic [14:0] pointer_x,
	input logic [14:0] pointer_y,
	input logic signed [7:0] wheel_delta,
	input logic [2:0]  buttons,
	input logic        rsp_valid,
	input logic        rsp_stall,
	input logic        nak,
	input logic [7:0]  report_byte,
	input logic        last_byte,
	input logic        wr_en,
	input logic [1:0]  wr_index,
	input logic [15:0] wr_data
);

	`PTRE_ASSERT(a_beat_hold, rsp_valid && rsp_stall |=> rsp_valid && $stable(report_byte) && $stable(nak) && $stable(last_byte), "stalled beat changed")
	`PTRE_ASSERT(a_nak_single, rsp_valid && nak |-> last_byte && report_byte == 8'h00, "malformed NAK beat")
	`PTRE_ASSERT(a_report_runs_on, rsp_valid && !rsp_stall && !last_byte |=> rsp_valid && !nak, "report broken off")
	`PTRE_ASSERT_ALWAYS(a_reset_quiet, !arst_n |-> !rsp_valid && !req_stall, "activity during reset")

endmodule

bind pen_tablet_report_engine_top ptre_checker u_chk (.*);

// File: sim/tb.sv
// Testbench for the pen tablet report engine: directed and random events and polls,
// with every report beat checked against a behavioural copy of the engine.
// Needs ptre_pkg and pen_tablet_report_engine_top; stands alone otherwise.
`timescale 1ns / 1ps

module tb;
	import ptre_pkg::*;

	localparam logic [1:0] REG_UNUSED = 2'd3;
	localparam int STALL_LIMIT = 1000;

	typedef struct packed {
		logic       nak;
		logic [7:0] data;
		logic       last;
	} beat_t;

	class tablet_report_model;
		bit        mode;
		bit [15:0] leave_ms;
		bit [15:0] ping_ms;
		bit [15:0] pen_x;
		bit [14:0] pen_y;
		bit [10:0] pressure;
		bit [2:0]  btns;
		bit        in_prox;
		bit        pen_chg;
		bit        prox_chg;
		bit [31:0] last_report;
		bit [31:0] last_event;
		beat_t     expected_beats[$];
		int        mismatches;

		function new();
			mode        = 1'b0;
			leave_ms    = LEAVE_RESET;
			ping_ms     = PING_RESET;
			pen_x       = '0;
			pen_y       = '0;
			pressure    = PRESSURE_RESET;
			btns        = '0;
			in_prox     = 1'b0;
			pen_chg     = 1'b0;
			prox_chg    = 1'b1;
			last_report = '0;
			last_event  = '0;
			mismatches  = 0;
		endfunction

		function void write_reg(logic [1:0] idx, logic [15:0] val);
			case (idx)
				REG_MODE: begin
					mode     = val[0];
					in_prox  = 1'b0;
					pen_chg  = 1'b0;
					prox_chg = 1'b1;
				end
				REG_LEAVE: leave_ms = val;
				REG_PING:  ping_ms  = val;
				default: ;
			endcase
		endfunction

		function void push_beat(bit n, bit [7:0] d, bit l);
			beat_t b;
			b.nak  = n;
			b.data = d;
			b.last = l;
			expected_beats.push_back(b);
		endfunction

		function void take_item(logic o, logic [31:0] now, logic [14:0] px, logic [14:0] py,
				logic signed [7:0] wd, logic [2:0] bt);
			longint    sx;
			longint    sy;
			int        p;
			bit [31:0] w[10];
			bit [31:0] pres;
			bit [31:0] hover;
			bit [31:0] tilt;
			bit [31:0] x32;
			bit [31:0] y32;
			bit [31:0] elapsed;
			if (o == OP_EVENT) begin
				if (!mode)
					return;
				sx = (longint'(px) * RES_X_DEFAULT) / 32767;
				sy = (longint'(py) * RES_Y_DEFAULT) / 32767;
				pen_x = (sx > 65535) ? 16'hFFFF : sx[15:0];
				pen_y = (sy > 32767) ? 15'h7FFF : sy[14:0];
				p = int'(pressure) - int'(wd) * 128;
				if (p < 128)
					p = 128;
				if (p > 2047)
					p = 2047;
				pressure   = p[10:0];
				btns       = bt;
				pen_chg    = 1'b1;
				last_event = now;
				if (!in_prox) begin
					in_prox  = 1'b1;
					prox_chg = 1'b1;
				end
				return;
			end
			if (!mode) begin
				push_beat(1'b1, 8'h00, 1'b1);
				return;
			end
			elapsed = now - last_event;
			if (in_prox && !pen_chg && elapsed > leave_ms) begin
				in_prox  = 1'b0;
				prox_chg = 1'b1;
			end
			elapsed = now - last_report;
			if (elapsed > ping_ms) begin
				if (in_prox)
					pen_chg = 1'b1;
				else
					prox_chg = 1'b1;
			end
			if (!pen_chg && !prox_chg) begin
				push_beat(1'b1, 8'h00, 1'b1);
				return;
			end
			last_report = now;
			if (prox_chg) begin
				prox_chg = 1'b0;
				w[0] = REPORT_ID_PEN;
				w[1] = FLAG_PROX | (in_prox ? (FLAG_READY | FLAG_SERIAL) : 8'h00);
				w[2] = TOOL_ID >> 4;
				w[3] = (TOOL_ID << 4) | (TOOL_SERIAL >> 28);
				w[4] = TOOL_SERIAL >> 20;
				w[5] = TOOL_SERIAL >> 12;
				w[6] = TOOL_SERIAL >> 4;
				w[7] = (TOOL_SERIAL << 4) | ((TOOL_ID >> 16) & 32'hF);
				w[8] = (TOOL_ID >> 8) & 32'hF0;
				for (int i = 0; i < 9; i++)
					push_beat(1'b0, w[i][7:0], i == 8);
				return;
			end
			pen_chg = 1'b0;
			pres  = btns[0] ? 32'(pressure) : 32'd0;
			hover = btns[0] ? 32'd0 : 32'(HOVER_DISTANCE);
			tilt  = 32'(TILT_CENTER);
			x32   = 32'(pen_x);
			y32   = 32'(pen_y);
			w[0] = REPORT_ID_PEN;
			w[1] = FLAG_PROX | FLAG_READY | FLAG_RANGE | (btns & 3'd6) | (pres & 32'd1);
			w[2] = x32 >> 9;
			w[3] = x32 >> 1;
			w[4] = y32 >> 9;
			w[5] = y32 >> 1;
			w[6] = pres >> 3;
			w[7] = ((pres & 32'd6) << 5) | ((tilt >> 1) & 32'h7F);
			w[8] = (tilt << 7) | (tilt & 32'h7F);
			w[9] = (hover << 2) | ((x32 & 32'd1) << 1) | (y32 & 32'd1);
			for (int i = 0; i < 10; i++)
				push_beat(1'b0, w[i][7:0], i == 9);
		endfunction

		function void check_beat(logic n, logic [7:0] d, logic l);
			beat_t b;
			if (expected_beats.size() == 0) begin
				$error("unexpected beat: nak %0d byte 0x%02h last %0d", n, d, l);
				mismatches++;
				return;
			end
			b = expected_beats.pop_front();
			if (b.nak !== n) begin
				$error("nak: expected %0d, got %0d", b.nak, n);
				mismatches++;
			end
			if (b.data !== d) begin
				$error("report_byte: expected 0x%02h, got 0x%02h", b.data, d);
				mismatches++;
			end
			if (b.last !== l) begin
				$error("last_byte: expected %0d, got %0d", b.last, l);
				mismatches++;
			end
		endfunction
	endclass

	logic              clk;
	logic              arst_n;
	logic              req_valid;
	logic              req_stall;
	logic              op;
	logic [31:0]       now_ms;
	logic [14:0]       pointer_x;
	logic [14:0]       pointer_y;
	logic signed [7:0] wheel_delta;
	logic [2:0]        buttons;
	logic              rsp_valid;
	logic              rsp_stall;
	logic              nak;
	logic [7:0]        report_byte;
	logic              last_byte;
	logic              wr_en;
	logic [1:0]        wr_index;
	logic [15:0]       wr_data;

	tablet_report_model model;
	int                 burst_left;
	int                 idle_cycles;
	bit [31:0]          clock_ms;
	bit                 squeeze_req;
	bit                 squeeze_done;

	pen_tablet_report_engine_top uut (
		.clk         (clk),
		.arst_n      (arst_n),
		.req_valid   (req_valid),
		.req_stall   (req_stall),
		.op          (op),
		.now_ms      (now_ms),
		.pointer_x   (pointer_x),
		.pointer_y   (pointer_y),
		.wheel_delta (wheel_delta),
		.buttons     (buttons),
		.rsp_valid   (rsp_valid),
		.rsp_stall   (rsp_stall),
		.nak         (nak),
		.report_byte (report_byte),
		.last_byte   (last_byte),
		.wr_en       (wr_en),
		.wr_index    (wr_index),
		.wr_data     (wr_data)
	);

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	function automatic logic [14:0] pick_coord();
		case ($urandom_range(0, 7))
			0: return 15'd0;
			1: return 15'h7FFF;
			default: return 15'($urandom_range(0, 32767));
		endcase
	endfunction

	task automatic pace();
		int gap;
		if (burst_left == 0) begin
			gap = $urandom_range(0, 12);
			if (gap != 0) begin
				req_valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			burst_left = $urandom_range(1, 10);
		end
		burst_left--;
	endtask

	task automatic send_item(logic o, logic [31:0] t, logic [14:0] x, logic [14:0] y,
			logic signed [7:0] wd, logic [2:0] bt);
		pace();
		req_valid   <= 1'b1;
		op          <= o;
		now_ms      <= t;
		pointer_x   <= x;
		pointer_y   <= y;
		wheel_delta <= wd;
		buttons     <= bt;
		do @(posedge clk); while (!(req_valid && !req_stall));
		model.take_item(o, t, x, y, wd, bt);
	endtask

	task automatic settle();
		req_valid <= 1'b0;
		while (model.expected_beats.size() != 0)
			@(posedge clk);
		repeat (10) @(posedge clk);
		burst_left = 0;
	endtask

	task automatic write_reg(logic [1:0] idx, logic [15:0] val);
		wr_en    <= 1'b1;
		wr_index <= idx;
		wr_data  <= val;
		@(posedge clk);
		model.write_reg(idx, val);
		wr_en <= 1'b0;
		@(posedge clk);
	endtask

	task automatic configure(logic m, logic [15:0] leave, logic [15:0] ping);
		settle();
		write_reg(REG_LEAVE, leave);
		write_reg(REG_PING, ping);
		write_reg(REG_MODE, {15'd0, m});
	endtask

	task automatic advance_clock();
		int advance;
		case ($urandom_range(0, 9))
			0: advance = 0;
			1, 2, 3: advance = $urandom_range(0, 40);
			4, 5: advance = int'(model.ping_ms) + int'($urandom_range(0, 2)) - 1;
			6, 7: advance = int'(model.leave_ms) + int'($urandom_range(0, 2)) - 1;
			8: advance = $urandom_range(0, 70000);
			default: advance = $urandom;
		endcase
		if (advance < 0)
			advance = 0;
		clock_ms = clock_ms + 32'(advance);
	endtask

	task automatic random_items(int count);
		logic              o;
		logic [14:0]       x;
		logic [14:0]       y;
		logic signed [7:0] wd;
		logic [2:0]        bt;
		repeat (count) begin
			advance_clock();
			o  = ($urandom_range(0, 99) < 50) ? OP_EVENT : OP_POLL;
			x  = pick_coord();
			y  = pick_coord();
			wd = ($urandom_range(0, 4) == 0) ? 8'($urandom_range(0, 255))
				: 8'($urandom_range(0, 6) - 3);
			bt = 3'($urandom_range(0, 7));
			send_item(o, clock_ms, x, y, wd, bt);
		end
	endtask

	// receiver: segments of steady, light, heavy and full stall, plus long holds
	initial begin
		int span;
		int style;
		rsp_stall = 1'b0;
		forever begin
			if (squeeze_req && !squeeze_done) begin
				repeat (150) begin
					@(posedge clk);
					rsp_stall <= 1'b1;
				end
				squeeze_done = 1'b1;
			end
			style = $urandom_range(0, 4);
			span  = (style == 4) ? $urandom_range(30, 60) : $urandom_range(5, 40);
			repeat (span) begin
				@(posedge clk);
				case (style)
					0: rsp_stall <= 1'b0;
					1: rsp_stall <= 1'($urandom_range(0, 1));
					2: rsp_stall <= ($urandom_range(0, 3) == 0);
					3: rsp_stall <= ($urandom_range(0, 3) != 0);
					default: rsp_stall <= ($urandom_range(0, 15) != 0);
				endcase
			end
		end
	end

	always @(posedge clk)
		if (arst_n && rsp_valid && !rsp_stall)
			model.check_beat(nak, report_byte, last_byte);

	always @(posedge clk) begin
		if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall))
			idle_cycles <= 0;
		else if (idle_cycles >= STALL_LIMIT) begin
			$display("tb: FAIL");
			$finish;
		end else
			idle_cycles <= idle_cycles + 1;
	end

	initial begin
		arst_n       = 1'b0;
		req_valid    = 1'b0;
		op           = OP_EVENT;
		now_ms       = '0;
		pointer_x    = '0;
		pointer_y    = '0;
		wheel_delta  = '0;
		buttons      = '0;
		wr_en        = 1'b0;
		wr_index     = REG_MODE;
		wr_data      = '0;
		idle_cycles  = 0;
		burst_left   = 0;
		squeeze_req  = 1'b0;
		squeeze_done = 1'b0;
		model        = new();
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// plain mode: event dropped, poll refused
		send_item(OP_EVENT, 32'd5, 15'd1234, 15'd4321, 8'sd3, 3'd1);
		send_item(OP_POLL, 32'd6, 15'd0, 15'd0, 8'sd0, 3'd0);

		configure(1'b1, 16'd100, 16'd50);
		write_reg(REG_UNUSED, 16'hFFFF);
		send_item(OP_POLL, 32'd1000, 15'd0, 15'd0, 8'sd0, 3'd0);
		send_item(OP_POLL, 32'd1010, 15'd0, 15'd0, 8'sd0, 3'd0);
		send_item(OP_EVENT, 32'd1020, 15'd0, 15'd0, 8'sd0, 3'd0);
		send_item(OP_POLL, 32'd1021, 15'd0, 15'd0, 8'sd0, 3'd0);
		send_item(OP_POLL, 32'd1022, 15'd0, 15'd0, 8'sd0, 3'd0);
		send_item(OP_EVENT, 32'd1030, 15'h7FFF, 15'h7FFF, -8'sd128, 3'd7);
		send_item(OP_POLL, 32'd1031, 15'd0, 15'd0, 8'sd0, 3'd0);
		send_item(OP_EVENT, 32'd1040, 15'd16384, 15'd1, 8'sd127, 3'd1);
		send_item(OP_POLL, 32'd1041, 15'd0, 15'd0, 8'sd0, 3'd0);
		send_item(OP_EVENT, 32'd1050, 15'd21845, 15'd10922, -8'sd1, 3'd5);
		send_item(OP_POLL, 32'd1051, 15'd0, 15'd0, 8'sd0, 3'd0);
		// ping gap equal to the register, then one past it
		send_item(OP_POLL, 32'd1101, 15'd0, 15'd0, 8'sd0, 3'd0);
		send_item(OP_POLL, 32'd1102, 15'd0, 15'd0, 8'sd0, 3'd0);
		// leave timeout, then keep-alive out of proximity
		send_item(OP_POLL, 32'd1151, 15'd0, 15'd0, 8'sd0, 3'd0);
		send_item(OP_POLL, 32'd1201, 15'd0, 15'd0, 8'sd0, 3'd0);
		send_item(OP_POLL, 32'd1202, 15'd0, 15'd0, 8'sd0, 3'd0);
		// time wraps past zero
		send_item(OP_EVENT, 32'hFFFF_FFF0, 15'h7FFF, 15'd0, 8'sd2, 3'd2);
		send_item(OP_POLL, 32'd5, 15'd0, 15'd0, 8'sd0, 3'd0);
		send_item(OP_POLL, 32'd6, 15'd0, 15'd0, 8'sd0, 3'd0);

		configure(1'b1, 16'd0, 16'd0);
		clock_ms    = $urandom;
		squeeze_req = 1'b1;
		random_items(25);
		configure(1'b1, 16'hFFFF, 16'hFFFF);
		random_items(25);
		configure(1'b1, 16'($urandom_range(0, 400)), 16'($urandom_range(0, 400)));
		random_items(30);
		configure(1'b0, 16'd5000, 16'd200);
		random_items(10);
		configure(1'b1, 16'($urandom_range(0, 65535)), 16'($urandom_range(0, 300)));
		clock_ms = 32'hFFFF_FF00;
		random_items(20);

		settle();
		if (model.mismatches == 0 && model.expected_beats.size() == 0)
			$display("tb: PASS");
		else
			$display("tb: FAIL");
		$finish;
	end

endmodule
